/* rtl/i2cmb_pkg.sv */
package i2cmb_pkg;

  localparam int unsigned TDATA_W = 16;
  localparam int unsigned TUSER_W = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_LIMIT = 1'd1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
  localparam logic [7:0] STRETCH_LIMIT_RST = 8'd100;
  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_START = 3'd1,
    K_WRITE = 3'd2,
    K_READ  = 3'd3,
    K_STOP  = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_ST_SDA_HI  = 5'd1,
    PH_ST_SCL_HI  = 5'd2,
    PH_ST_SDA_LO  = 5'd3,
    PH_ST_SCL_LO  = 5'd4,
    PH_SP_SDA_LO  = 5'd5,
    PH_SP_SCL_HI  = 5'd6,
    PH_SP_SDA_HI  = 5'd7,
    PH_WR_BIT     = 5'd8,
    PH_WR_SCL_HI  = 5'd9,
    PH_WR_SCL_LO  = 5'd10,
    PH_WR_ACK_REL = 5'd11,
    PH_WR_ACK_SCL = 5'd12,
    PH_WR_ACK_LO  = 5'd13,
    PH_RD_REL     = 5'd14,
    PH_RD_SCL_HI  = 5'd15,
    PH_RD_SCL_LO  = 5'd16,
    PH_RD_ACK     = 5'd17,
    PH_RD_ACK_SCL = 5'd18,
    PH_RD_ACK_LO  = 5'd19,
    PH_RD_END     = 5'd20,
    PH_FINISH     = 5'd21
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] wval;
    logic       gack;
    logic       scl;
    logic       sda;
  } item_t;

  function automatic logic after_scl_release(phase_t ph);
    return (ph == PH_ST_SDA_LO) || (ph == PH_SP_SDA_HI) || (ph == PH_WR_SCL_LO) ||
           (ph == PH_WR_ACK_LO) || (ph == PH_RD_SCL_LO) || (ph == PH_RD_ACK_LO);
  endfunction

endpackage

/* rtl/i2cmb_front.sv */
module i2cmb_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // write_value[7:0], give_ack[8], scl_level[9], sda_level[10]
  input  logic [i2cmb_pkg::TDATA_W-1:0]   in_tdata,
  // func[2:0]
  input  logic [i2cmb_pkg::TUSER_W-1:0]   in_tuser,
  input  logic                            q_full,
  output logic                            q_push,
  output i2cmb_pkg::item_t                q_item
);
  import i2cmb_pkg::*;

  kind_t kind;

  always_comb begin
    unique case (in_tuser)
      K_START: kind = K_START;
      K_WRITE: kind = K_WRITE;
      K_READ:  kind = K_READ;
      K_STOP:  kind = K_STOP;
      default: kind = K_NONE;
    endcase
  end

  assign in_tready   = ~q_full;
  assign q_push      = in_tvalid & ~q_full;
  assign q_item.kind = kind;
  assign q_item.wval = in_tdata[7:0];
  assign q_item.gack = in_tdata[8];
  assign q_item.scl  = in_tdata[9];
  assign q_item.sda  = in_tdata[10];

endmodule

/* rtl/i2cmb_queue.sv */
module i2cmb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cmb_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output i2cmb_pkg::item_t  head
);
  import i2cmb_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  item_t              mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/i2cmb_back.sv */
module i2cmb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cmb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              q_valid,
  input  i2cmb_pkg::item_t                  q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cmb_pkg::TDATA_W-1:0]     out_tdata
);
  import i2cmb_pkg::*;

  logic [7:0] ph_ticks_r, str_lim_r;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [7:0] stretch_r, stretch_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic       nack_r, nack_nxt;
  logic       tmo_r, tmo_nxt;
  logic [7:0] rdhold_r, rdhold_nxt;
  logic       done, ignored, act;
  phase_t     act_ph;
  logic       is_cmd;
  logic [3:0] bit_inc;

  logic                 out_valid_r;
  logic [TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic                 go;

  assign go         = q_valid & (~out_valid_r | out_tready);
  assign q_pop      = go;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign is_cmd     = (q_head.kind != K_NONE);

  always_comb begin
    phase_nxt   = phase_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    wait_nxt    = wait_r;
    stretch_nxt = stretch_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_nxt     = ack_r;
    nack_nxt    = nack_r;
    tmo_nxt     = tmo_r;
    rdhold_nxt  = rdhold_r;
    done        = 1'b0;
    ignored     = 1'b0;
    act         = 1'b0;
    act_ph      = PH_IDLE;
    bit_inc     = '0;

    if (phase_r == PH_IDLE) begin
      if (is_cmd) begin
        bit_nxt     = '0;
        stretch_nxt = '0;
        tmo_nxt     = 1'b0;
        ack_nxt     = q_head.gack;
        act         = 1'b1;
        unique case (q_head.kind)
          K_WRITE: begin
            shift_nxt = q_head.wval;
            nack_nxt  = 1'b0;
            act_ph    = PH_WR_BIT;
          end
          K_READ: begin
            shift_nxt = '0;
            act_ph    = PH_RD_REL;
          end
          K_STOP:  act_ph = PH_SP_SDA_LO;
          default: act_ph = PH_ST_SDA_HI;
        endcase
      end
    end else begin
      ignored = is_cmd;
      priority if (phase_r > PH_FINISH) begin
        phase_nxt = PH_IDLE;
      end else if (wait_r != '0) begin
        wait_nxt = wait_r - 1'b1;
      end else if (phase_r == PH_FINISH) begin
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end else if (after_scl_release(phase_r) && !q_head.scl && (stretch_r < str_lim_r)) begin
        stretch_nxt = stretch_r + 1'b1;
      end else begin
        if (after_scl_release(phase_r)) begin
          if (!q_head.scl) begin
            tmo_nxt = 1'b1;
          end
          stretch_nxt = '0;
        end
        act    = 1'b1;
        act_ph = phase_r;
      end
    end

    if (act) begin
      bit_inc  = bit_nxt + 1'b1;
      wait_nxt = (ph_ticks_r != '0) ? ph_ticks_r - 1'b1 : '0;
      unique case (act_ph)
        PH_ST_SDA_HI: begin sda_nxt = 1'b0; phase_nxt = PH_ST_SCL_HI; end
        PH_ST_SCL_HI: begin scl_nxt = 1'b0; phase_nxt = PH_ST_SDA_LO; end
        PH_ST_SDA_LO: begin sda_nxt = 1'b1; phase_nxt = PH_ST_SCL_LO; end
        PH_ST_SCL_LO: begin scl_nxt = 1'b1; phase_nxt = PH_FINISH; end
        PH_SP_SDA_LO: begin sda_nxt = 1'b1; phase_nxt = PH_SP_SCL_HI; end
        PH_SP_SCL_HI: begin scl_nxt = 1'b0; phase_nxt = PH_SP_SDA_HI; end
        PH_SP_SDA_HI: begin sda_nxt = 1'b0; phase_nxt = PH_FINISH; end
        PH_WR_BIT: begin
          sda_nxt   = ((shift_nxt & MSB_MASK) == '0);
          phase_nxt = PH_WR_SCL_HI;
        end
        PH_WR_SCL_HI: begin scl_nxt = 1'b0; phase_nxt = PH_WR_SCL_LO; end
        PH_WR_SCL_LO: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_nxt[6:0], 1'b0};
          bit_nxt   = bit_inc;
          phase_nxt = (bit_inc >= BITS_PER_BYTE) ? PH_WR_ACK_REL : PH_WR_BIT;
        end
        PH_WR_ACK_REL: begin sda_nxt = 1'b0; phase_nxt = PH_WR_ACK_SCL; end
        PH_WR_ACK_SCL: begin scl_nxt = 1'b0; phase_nxt = PH_WR_ACK_LO; end
        PH_WR_ACK_LO: begin
          nack_nxt  = q_head.sda;
          scl_nxt   = 1'b1;
          phase_nxt = PH_FINISH;
        end
        PH_RD_REL:    begin sda_nxt = 1'b0; phase_nxt = PH_RD_SCL_HI; end
        PH_RD_SCL_HI: begin scl_nxt = 1'b0; phase_nxt = PH_RD_SCL_LO; end
        PH_RD_SCL_LO: begin
          shift_nxt = {shift_nxt[6:0], q_head.sda};
          scl_nxt   = 1'b1;
          bit_nxt   = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            rdhold_nxt = {shift_r[6:0], q_head.sda};
            phase_nxt  = PH_RD_ACK;
          end else begin
            phase_nxt = PH_RD_SCL_HI;
          end
        end
        PH_RD_ACK:     begin sda_nxt = ack_nxt; phase_nxt = PH_RD_ACK_SCL; end
        PH_RD_ACK_SCL: begin scl_nxt = 1'b0; phase_nxt = PH_RD_ACK_LO; end
        PH_RD_ACK_LO:  begin scl_nxt = 1'b1; phase_nxt = PH_RD_END; end
        PH_RD_END:     begin sda_nxt = 1'b0; phase_nxt = PH_FINISH; end
        default:       phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[0]    = scl_nxt;
    out_data_nxt[1]    = sda_nxt;
    out_data_nxt[2]    = (phase_nxt != PH_IDLE);
    out_data_nxt[3]    = done;
    out_data_nxt[11:4] = rdhold_nxt;
    out_data_nxt[12]   = nack_nxt;
    out_data_nxt[13]   = tmo_nxt;
    out_data_nxt[14]   = ignored;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_ticks_r  <= PHASE_TICKS_RST;
      str_lim_r   <= STRETCH_LIMIT_RST;
      phase_r     <= PH_IDLE;
      bit_r       <= '0;
      shift_r     <= '0;
      wait_r      <= '0;
      stretch_r   <= '0;
      scl_r       <= 1'b0;
      sda_r       <= 1'b0;
      ack_r       <= 1'b0;
      nack_r      <= 1'b0;
      tmo_r       <= 1'b0;
      rdhold_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_PHASE_TICKS:   ph_ticks_r <= cfg_data;
          REG_STRETCH_LIMIT: str_lim_r  <= cfg_data;
          default: ;
        endcase
      end
      if (go) begin
        phase_r   <= phase_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        wait_r    <= wait_nxt;
        stretch_r <= stretch_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        ack_r     <= ack_nxt;
        nack_r    <= nack_nxt;
        tmo_r     <= tmo_nxt;
        rdhold_r  <= rdhold_nxt;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* rtl/i2c_master_byte_engine.sv */
// A word accepted into the two-entry queue is popped by the engine, and its result
// word is registered in an output slot. Throughput: one word per cycle while the
// sink is ready; queue and slot part the engine from the input side and the sink.
// Reset: synchronous, active low; clears queue, engine state and output valid,
// sets phase_ticks to 1 and stretch_limit to 100. No clearing pass.
module i2c_master_byte_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cmb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // write_value[7:0], give_ack[8], scl_level[9], sda_level[10], zero fill
  input  logic [i2cmb_pkg::TDATA_W-1:0]     in_tdata,
  // func[2:0]
  input  logic [i2cmb_pkg::TUSER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // scl_pull_low[0], sda_pull_low[1], busy_res[2], done_res[3], read_value[11:4],
  // no_ack[12], stretch_expired[13], cmd_ignored[14], zero fill
  output logic [i2cmb_pkg::TDATA_W-1:0]     out_tdata
);
  import i2cmb_pkg::*;

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_item, q_head;

  i2cmb_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  i2cmb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  i2cmb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* tb/i2cmb_checker.sv */
`timescale 1ns / 100ps

module i2cmb_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cmb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [i2cmb_pkg::TDATA_W-1:0]    in_tdata,
  input  logic [i2cmb_pkg::TUSER_W-1:0]    in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [i2cmb_pkg::TDATA_W-1:0]    out_tdata,
  output int                               mismatches,
  output int                               pending
);
  import i2cmb_pkg::*;

  typedef struct packed {
    logic       ignored;
    logic       timed_out;
    logic       nack;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda_low;
    logic       scl_low;
  } line_state_t;

  line_state_t lines_due[$];
  int          words_seen;

  logic [7:0]  hold_ticks;
  logic [7:0]  stretch_max;
  phase_t      ph;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [7:0]  hold_cnt;
  logic [7:0]  stretch_cnt;
  logic [7:0]  rx_hold;
  logic        scl_pull;
  logic        sda_pull;
  logic        ack_sel;
  logic        nack_flag;
  logic        tmo_flag;

  function automatic logic waits_for_scl(phase_t p);
    case (p)
      PH_ST_SDA_LO, PH_SP_SDA_HI, PH_WR_SCL_LO,
      PH_WR_ACK_LO, PH_RD_SCL_LO, PH_RD_ACK_LO: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic drive_pins(input phase_t p, input logic sda_in);
    phase_t nxt;
    nxt = PH_IDLE;
    case (p)
      PH_ST_SDA_HI: begin sda_pull = 1'b0; nxt = PH_ST_SCL_HI; end
      PH_ST_SCL_HI: begin scl_pull = 1'b0; nxt = PH_ST_SDA_LO; end
      PH_ST_SDA_LO: begin sda_pull = 1'b1; nxt = PH_ST_SCL_LO; end
      PH_ST_SCL_LO: begin scl_pull = 1'b1; nxt = PH_FINISH; end
      PH_SP_SDA_LO: begin sda_pull = 1'b1; nxt = PH_SP_SCL_HI; end
      PH_SP_SCL_HI: begin scl_pull = 1'b0; nxt = PH_SP_SDA_HI; end
      PH_SP_SDA_HI: begin sda_pull = 1'b0; nxt = PH_FINISH; end
      PH_WR_BIT: begin
        sda_pull = ~shreg[7];
        nxt = PH_WR_SCL_HI;
      end
      PH_WR_SCL_HI: begin scl_pull = 1'b0; nxt = PH_WR_SCL_LO; end
      PH_WR_SCL_LO: begin
        scl_pull = 1'b1;
        shreg = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        nxt = (bit_cnt >= BITS_PER_BYTE) ? PH_WR_ACK_REL : PH_WR_BIT;
      end
      PH_WR_ACK_REL: begin sda_pull = 1'b0; nxt = PH_WR_ACK_SCL; end
      PH_WR_ACK_SCL: begin scl_pull = 1'b0; nxt = PH_WR_ACK_LO; end
      PH_WR_ACK_LO: begin
        nack_flag = sda_in;
        scl_pull = 1'b1;
        nxt = PH_FINISH;
      end
      PH_RD_REL: begin sda_pull = 1'b0; nxt = PH_RD_SCL_HI; end
      PH_RD_SCL_HI: begin scl_pull = 1'b0; nxt = PH_RD_SCL_LO; end
      PH_RD_SCL_LO: begin
        shreg = {shreg[6:0], sda_in};
        scl_pull = 1'b1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= BITS_PER_BYTE) begin
          rx_hold = shreg;
          nxt = PH_RD_ACK;
        end else begin
          nxt = PH_RD_SCL_HI;
        end
      end
      PH_RD_ACK: begin sda_pull = ack_sel; nxt = PH_RD_ACK_SCL; end
      PH_RD_ACK_SCL: begin scl_pull = 1'b0; nxt = PH_RD_ACK_LO; end
      PH_RD_ACK_LO: begin scl_pull = 1'b1; nxt = PH_RD_END; end
      PH_RD_END: begin sda_pull = 1'b0; nxt = PH_FINISH; end
      default: nxt = PH_IDLE;
    endcase
    ph = nxt;
    hold_cnt = (hold_ticks != 8'd0) ? hold_ticks - 8'd1 : 8'd0;
  endtask

  task automatic tick_engine(input logic [2:0] f, input logic [7:0] wv, input logic ga,
                             input logic scl_in, input logic sda_in,
                             output line_state_t res);
    logic   is_cmd;
    logic   done;
    logic   ign;
    phase_t first;
    is_cmd = 1'b0;
    done = 1'b0;
    ign = 1'b0;
    case (f)
      K_START, K_WRITE, K_READ, K_STOP: is_cmd = 1'b1;
      default: is_cmd = 1'b0;
    endcase
    if (ph == PH_IDLE) begin
      if (is_cmd) begin
        bit_cnt = 4'd0;
        stretch_cnt = 8'd0;
        tmo_flag = 1'b0;
        ack_sel = ga;
        case (f)
          K_WRITE: begin
            shreg = wv;
            nack_flag = 1'b0;
            first = PH_WR_BIT;
          end
          K_READ: begin
            shreg = 8'd0;
            first = PH_RD_REL;
          end
          K_STOP: first = PH_SP_SDA_LO;
          default: first = PH_ST_SDA_HI;
        endcase
        drive_pins(first, sda_in);
      end
    end else begin
      ign = is_cmd;
      if (hold_cnt != 8'd0) begin
        hold_cnt = hold_cnt - 8'd1;
      end else if (ph == PH_FINISH) begin
        done = 1'b1;
        ph = PH_IDLE;
      end else if (waits_for_scl(ph) && !scl_in && stretch_cnt < stretch_max) begin
        stretch_cnt = stretch_cnt + 8'd1;
      end else begin
        if (waits_for_scl(ph)) begin
          if (!scl_in) tmo_flag = 1'b1;
          stretch_cnt = 8'd0;
        end
        drive_pins(ph, sda_in);
      end
    end
    res.ignored = ign;
    res.timed_out = tmo_flag;
    res.nack = nack_flag;
    res.rx_byte = rx_hold;
    res.done = done;
    res.busy = (ph != PH_IDLE);
    res.sda_low = sda_pull;
    res.scl_low = scl_pull;
  endtask

  always @(posedge clk) begin
    line_state_t want;
    line_state_t got;
    if (!rst_n) begin
      hold_ticks = PHASE_TICKS_RST;
      stretch_max = STRETCH_LIMIT_RST;
      ph = PH_IDLE;
      bit_cnt = 4'd0;
      shreg = 8'd0;
      hold_cnt = 8'd0;
      stretch_cnt = 8'd0;
      rx_hold = 8'd0;
      scl_pull = 1'b0;
      sda_pull = 1'b0;
      ack_sel = 1'b0;
      nack_flag = 1'b0;
      tmo_flag = 1'b0;
      lines_due.delete();
      words_seen = 0;
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PHASE_TICKS:   hold_ticks = cfg_data;
          REG_STRETCH_LIMIT: stretch_max = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        tick_engine(in_tuser, in_tdata[7:0], in_tdata[8], in_tdata[9], in_tdata[10], want);
        lines_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = line_state_t'(out_tdata[$bits(line_state_t)-1:0]);
        if (lines_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: result %h with nothing outstanding", words_seen, out_tdata);
        end else begin
          want = lines_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word %0d: exp scl=%b sda=%b busy=%b done=%b rd=%h nack=%b tmo=%b ign=%b",
                       words_seen, want.scl_low, want.sda_low, want.busy, want.done,
                       want.rx_byte, want.nack, want.timed_out, want.ignored);
              $display("word %0d: got scl=%b sda=%b busy=%b done=%b rd=%h nack=%b tmo=%b ign=%b",
                       words_seen, got.scl_low, got.sda_low, got.busy, got.done,
                       got.rx_byte, got.nack, got.timed_out, got.ignored);
            end
          end
        end
        words_seen++;
      end
    end
    pending = lines_due.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import i2cmb_pkg::*;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata = '0;
  logic [TUSER_W-1:0]    in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  int                    mismatches;
  int                    pending;

  int         words_sent = 0;
  int         burst_left = 0;
  int         low_left = 0;
  int         stretch_pct = 0;
  int         low_max = 4;
  logic [7:0] tick_cfg = PHASE_TICKS_RST;
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_span = 0;
  int         rx_count = 0;

  i2c_master_byte_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  i2cmb_checker engine_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(16, 160);
    end
    rx_span--;
    rx_count++;
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_tready <= ((rx_count % 5) < 3);
      default:     out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_word(input logic [2:0] f, input logic [7:0] wv, input logic ga,
                           input logic sc, input logic sd);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : int'($urandom_range(1, 24));
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= TDATA_W'({sd, sc, ga, wv});
    in_tuser <= f;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // model the bus: SCL mostly high, with runs held low by a stretching slave
  task automatic bus_tick(input logic [2:0] f, output logic sc);
    if (low_left > 0) begin
      sc = 1'b0;
      low_left--;
    end else if ($urandom_range(0, 99) < stretch_pct) begin
      sc = 1'b0;
      low_left = $urandom_range(0, low_max);
    end else begin
      sc = 1'b1;
    end
    push_word(f, pick_byte(), 1'($urandom_range(0, 1)), sc, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_cmd(input kind_t k);
    int   pt;
    int   left;
    logic sc;
    pt = (tick_cfg == 8'd0) ? 1 : int'(tick_cfg);
    case (k)
      K_START: left = 4 * pt;
      K_STOP:  left = 3 * pt;
      K_WRITE: left = 27 * pt;
      default: left = 21 * pt;
    endcase
    left = left + int'($urandom_range(0, 5)) - 2;
    bus_tick(3'(k), sc);
    // hold off the next command until the engine should be idle again
    while (left > 0) begin
      bus_tick(($urandom_range(0, 29) == 0) ? 3'($urandom_range(0, 7)) : 3'(K_NONE), sc);
      if (sc) left--;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int txn_count;
    int nbytes;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int c = int'(K_STOP) + 1; c < 8; c++)
      push_word(3'(c), 8'h00, 1'b0, 1'b1, 1'b1);
    push_word(K_START, 8'h00, 1'b0, 1'b1, 1'b1);
    push_word(K_WRITE, 8'hA5, 1'b1, 1'b1, 1'b1);
    push_word(K_NONE, 8'hFF, 1'b1, 1'b1, 1'b0);
    push_word(K_NONE, 8'h00, 1'b0, 1'b1, 1'b1);
    push_word(K_STOP, 8'h5A, 1'b0, 1'b1, 1'b1);

    drain_pipe();
    tick_cfg = 8'd0;
    write_reg(REG_PHASE_TICKS, 8'd0);
    write_reg(REG_STRETCH_LIMIT, 8'd0);
    push_word(K_STOP, 8'hFF, 1'b1, 1'b0, 1'b0);
    repeat (3) push_word(K_NONE, 8'h00, 1'b0, 1'b0, 1'b0);

    drain_pipe();
    tick_cfg = 8'd255;
    write_reg(REG_PHASE_TICKS, 8'd255);
    write_reg(REG_STRETCH_LIMIT, 8'd255);
    stretch_pct = 2;
    low_max = 30;
    run_cmd(K_STOP);

    while (words_sent < 1100) begin
      drain_pipe();
      case ($urandom_range(0, 5))
        0:       tick_cfg = 8'd0;
        1, 2:    tick_cfg = 8'd1;
        3:       tick_cfg = 8'd2;
        4:       tick_cfg = 8'd3;
        default: tick_cfg = 8'd4;
      endcase
      write_reg(REG_PHASE_TICKS, tick_cfg);
      case ($urandom_range(0, 6))
        0:       write_reg(REG_STRETCH_LIMIT, 8'd0);
        1:       write_reg(REG_STRETCH_LIMIT, 8'd1);
        2:       write_reg(REG_STRETCH_LIMIT, 8'd3);
        3:       write_reg(REG_STRETCH_LIMIT, 8'd10);
        4:       write_reg(REG_STRETCH_LIMIT, 8'd100);
        5:       write_reg(REG_STRETCH_LIMIT, 8'd255);
        default: write_reg(REG_STRETCH_LIMIT, 8'($urandom_range(0, 255)));
      endcase
      stretch_pct = $urandom_range(0, 12);
      low_max = $urandom_range(1, 12);
      txn_count = $urandom_range(1, 3);
      repeat (txn_count) begin
        if ($urandom_range(0, 7) != 0) run_cmd(K_START);
        nbytes = $urandom_range(1, 3);
        repeat (nbytes) run_cmd(($urandom_range(0, 2) != 0) ? K_WRITE : K_READ);
        if ($urandom_range(0, 7) != 0) run_cmd(K_STOP);
      end
    end

    drain_pipe();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
